FILE: hdl/mm63_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm63_pkg: shared types and constants for the 63-bit modular multiplier
// Holds the operand width and the input and result transfer structs.
// ----------------------------------------------------------------------------
package mm63_pkg;

  // Width of every operand field on the ports
  localparam int OPND_W = 63;

  // Default number of operand bits used by the datapath
  localparam int DEF_OPERAND_BITS = 63;

  // One input transfer: factors and modulus
  typedef struct packed {
    logic [OPND_W-1:0] multiplicand;
    logic [OPND_W-1:0] multiplier;
    logic [OPND_W-1:0] modulus;
  } mm63_in_t;

  // One result transfer: reduced product and zero-modulus flag
  typedef struct packed {
    logic [OPND_W-1:0] product_mod;
    logic              zero_modulus;
  } mm63_out_t;

endpackage

FILE: hdl/modular_multiplier_63bit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_multiplier_63bit: (multiplicand * multiplier) mod modulus
// Shift-and-add modular multiplier that keeps every partial result below the
// modulus, with a registered result stage in front of the output channel.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------
//   in      | in_valid, in_ready, in_data    | multiplicand, multiplier, modulus
//   out     | out_valid, out_ready, out_data | product_mod, zero_modulus
//
// The engine takes one input at a time: it reduces the multiplier modulo the
// modulus bit by bit, then runs one add-and-double step through the step
// unit per multiplicand bit, then holds the result for the result register,
// which loads it as the engine returns to idle. A zero modulus skips both
// phases and goes straight to handing the result on. Reset is synchronous,
// active low, and clears only control state.
// A stalled result waits in the output register; the engine takes the next
// input meanwhile and holds its own result until that register frees up.
// ----------------------------------------------------------------------------
module modular_multiplier_63bit #(
  parameter int OPERAND_BITS = mm63_pkg::DEF_OPERAND_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mm63_pkg::mm63_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mm63_pkg::mm63_out_t  out_data
);

  logic                core_res_valid;
  logic                core_res_ready;
  mm63_pkg::mm63_out_t core_res;
  logic                out_valid_r;
  mm63_pkg::mm63_out_t out_data_r;

  // Engine
  mm63_core #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (in_data),
    .res_valid (core_res_valid),
    .res_ready (core_res_ready),
    .res       (core_res)
  );

  // Output register: load when empty or draining
  assign core_res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_res_valid && core_res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res_valid && core_res_ready) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("engine still ready after an input transfer");

  a_idle_excl_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && core_res_valid))
    else $error("engine idle and holding a result at once");

  a_zero_mod_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_modulus) |-> (out_data.product_mod == '0))
    else $error("nonzero product on a zero modulus");

  a_result_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.product_mod >> OPERAND_BITS) == '0))
    else $error("product has bits above the operand width");

endmodule

FILE: hdl/mm63_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm63_core: iterative shift-and-add modular multiply engine
// A small sequencer drives one step unit with two fold lanes. The reduce
// phase runs restoring division of the multiplier by the modulus, one bit a
// cycle; the multiply phase adds the addend for each set multiplicand bit and
// doubles the addend, each followed by one conditional subtract.
// ----------------------------------------------------------------------------
module mm63_core #(
  parameter int OPERAND_BITS = mm63_pkg::DEF_OPERAND_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  mm63_pkg::mm63_in_t   req,
  output logic                 res_valid,
  input  logic                 res_ready,
  output mm63_pkg::mm63_out_t  res
);

  localparam int W  = OPERAND_BITS;
  localparam int CW = $clog2(W);
  localparam int OW = mm63_pkg::OPND_W;
  localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_REDUCE = 4'b0010,
    ST_MULT   = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  m_r, m_nxt;
  logic [W-1:0]  addend_r, addend_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic          zero_r, zero_nxt;

  // Step unit lanes
  logic [W:0]    lane_a_in;
  logic [W:0]    lane_a_diff;
  logic [W-1:0]  lane_a_out;
  logic [W:0]    lane_b_in;
  logic [W:0]    lane_b_diff;
  logic [W-1:0]  lane_b_out;

  // Lane A: shift in the next dividend bit (reduce) or double (multiply), then fold
  always_comb begin
    if (state_r == ST_REDUCE) begin
      lane_a_in = {addend_r, b_r[W-1]};
    end else begin
      lane_a_in = {addend_r, 1'b0};
    end
    lane_a_diff = lane_a_in - {1'b0, m_r};
    if (lane_a_in >= {1'b0, m_r}) begin
      lane_a_out = lane_a_diff[W-1:0];
    end else begin
      lane_a_out = lane_a_in[W-1:0];
    end
  end

  // Lane B: accumulate the addend, then fold
  always_comb begin
    lane_b_in   = {1'b0, acc_r} + {1'b0, addend_r};
    lane_b_diff = lane_b_in - {1'b0, m_r};
    if (lane_b_in >= {1'b0, m_r}) begin
      lane_b_out = lane_b_diff[W-1:0];
    end else begin
      lane_b_out = lane_b_in[W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    m_nxt      = m_r;
    addend_nxt = addend_r;
    acc_nxt    = acc_r;
    zero_nxt   = zero_r;
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          a_nxt      = req.multiplicand[W-1:0];
          b_nxt      = req.multiplier[W-1:0];
          m_nxt      = req.modulus[W-1:0];
          addend_nxt = '0;
          acc_nxt    = '0;
          cnt_nxt    = LAST_STEP;
          zero_nxt   = (req.modulus[W-1:0] == '0);
          if (req.modulus[W-1:0] == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        addend_nxt = lane_a_out;
        b_nxt      = b_r << 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          cnt_nxt   = LAST_STEP;
          state_nxt = ST_MULT;
        end
      end
      ST_MULT: begin
        if (a_r[0]) begin
          acc_nxt = lane_b_out;
        end
        addend_nxt = lane_a_out;
        a_nxt      = a_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    m_r      <= m_nxt;
    addend_r <= addend_nxt;
    acc_r    <= acc_nxt;
    zero_r   <= zero_nxt;
  end

  // Handshake and result
  assign req_ready        = (state_r == ST_IDLE);
  assign res_valid        = (state_r == ST_DONE);
  assign res.product_mod  = OW'(acc_r);
  assign res.zero_modulus = zero_r;

endmodule

FILE: tb/mm63_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm63_result_checker: scoreboard for the 63-bit modular multiplier
// Watches both channels, predicts (multiplicand * multiplier) mod modulus for
// every input transfer from the exact 126-bit product, and compares each
// result transfer field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module mm63_result_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mm63_pkg::mm63_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mm63_pkg::mm63_out_t out_data,
  output int                  error_count,
  output int                  products_due
);

  // Predictions in transfer order, oldest at the front
  mm63_pkg::mm63_out_t due_products[$];
  int                  mismatches = 0;

  // Reduce the full double-width product; a zero modulus flags and gives 0
  function automatic mm63_pkg::mm63_out_t mod_product(input mm63_pkg::mm63_in_t t);
    logic [2*mm63_pkg::OPND_W-1:0] full;
    mm63_pkg::mm63_out_t           res;
    res.product_mod  = '0;
    res.zero_modulus = 1'b1;
    if (t.modulus != '0) begin
      full = {{mm63_pkg::OPND_W{1'b0}}, t.multiplicand} *
             {{mm63_pkg::OPND_W{1'b0}}, t.multiplier};
      full = full % {{mm63_pkg::OPND_W{1'b0}}, t.modulus};
      res.product_mod  = full[mm63_pkg::OPND_W-1:0];
      res.zero_modulus = 1'b0;
    end
    return res;
  endfunction

  // Count a failure; print only the first few
  task automatic flag_error(input string what,
                            input logic [mm63_pkg::OPND_W-1:0] want,
                            input logic [mm63_pkg::OPND_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected 0x%016h, got 0x%016h",
               $realtime, what, want, got);
  endtask

  // Record predictions on input transfers, retire them on result transfers
  always @(posedge clk) begin : watch
    mm63_pkg::mm63_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        due_products.push_back(mod_product(in_data));
      if (out_valid && out_ready) begin
        if (due_products.size() == 0) begin
          flag_error("result with nothing pending", '0, out_data.product_mod);
        end else begin
          want = due_products.pop_front();
          if (out_data.product_mod !== want.product_mod)
            flag_error("product_mod", want.product_mod, out_data.product_mod);
          if (out_data.zero_modulus !== want.zero_modulus)
            flag_error("zero_modulus", mm63_pkg::OPND_W'(want.zero_modulus),
                       mm63_pkg::OPND_W'(out_data.zero_modulus));
        end
      end
    end
    error_count  <= mismatches;
    products_due <= due_products.size();
  end

endmodule

FILE: tb/modular_multiplier_63bit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_multiplier_63bit_test: top of the modular multiplier testbench
// Drives directed corner items (extreme operands, zero and unit modulus,
// factors above the modulus) and then random operand triples through the
// input channel with random idle gaps on both sides and one long result
// stall; the checker predicts and compares, this top gives the verdict.
// ----------------------------------------------------------------------------
module modular_multiplier_63bit_test;

  localparam int OPND_W = mm63_pkg::OPND_W;

  localparam logic [OPND_W-1:0] OPND_MAX   = '1;
  localparam logic [OPND_W-1:0] OPND_TOP   = {1'b1, {(OPND_W-1){1'b0}}};
  localparam int                RAND_ITEMS = 1550;
  localparam int                HOLD_AFTER = 30;
  localparam int                HOLD_LEN   = 800;
  localparam int                DRAIN_WAIT = 300;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  mm63_pkg::mm63_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mm63_pkg::mm63_out_t out_data;
  int                  error_count;
  int                  products_due;
  int                  items_sent = 0;

  always #5 clk = ~clk;

  modular_multiplier_63bit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  mm63_result_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .error_count  (error_count),
    .products_due (products_due)
  );

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  function automatic logic [OPND_W-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[OPND_W-1:0];
  endfunction

  // Random operand, biased toward zero, max and values around the modulus
  function automatic logic [OPND_W-1:0] rand_factor(input logic [OPND_W-1:0] m);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 14) return OPND_MAX;
    if (r < 20) return (m == '0) ? '0 : m - 1'b1;
    if (r < 26) return m;
    if (r < 35) return OPND_W'($urandom_range(0, 15));
    if (r < 70) return rand_word();
    return rand_word() >> $urandom_range(1, OPND_W - 1);
  endfunction

  function automatic logic [OPND_W-1:0] rand_modulus();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return OPND_W'(1);
    if (r < 10) return OPND_MAX;
    if (r < 14) return OPND_TOP >> $urandom_range(0, OPND_W - 1);
    if (r < 55) return rand_word();
    return rand_word() >> $urandom_range(1, OPND_W - 1);
  endfunction

  // Offer one item at the falling edge and hold it until the transfer
  task automatic send(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b,
                      input logic [OPND_W-1:0] m);
    int gap;
    @(negedge clk);
    in_data  = '{multiplicand: a, multiplier: b, modulus: m};
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    gap = ((items_sent / 100) % 4 == 2) ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Result side: random stalls, a calm stretch now and then, one long hold-off
  initial begin : receiver
    int  stall;
    int  cyc;
    bit  held;
    stall = 0;
    cyc   = 0;
    held  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (!held && items_sent >= HOLD_AFTER) begin
        held      = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end else if ((cyc / 3000) % 3 == 1) begin
        out_ready = 1'b1;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        stall     = idle_len();
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    logic [OPND_W-1:0] m;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Extremes, zero and unit modulus, factors above the modulus
    send('0, '0, OPND_MAX);
    send(OPND_MAX, OPND_MAX, OPND_MAX);
    send(OPND_MAX, OPND_MAX, OPND_MAX - 1'b1);
    send(OPND_MAX, OPND_MAX, '0);
    send('0, '0, '0);
    send(OPND_W'(123), OPND_W'(456), OPND_W'(1));
    send(OPND_MAX, OPND_MAX, OPND_W'(1));
    send(OPND_W'(1), OPND_MAX, OPND_TOP);
    send(OPND_W'(1000), OPND_W'(2000), OPND_W'(7));
    send(OPND_MAX, OPND_MAX - 1'b1, OPND_TOP + 1'b1);
    send(OPND_W'(1), OPND_W'(1), OPND_MAX);
    send(OPND_TOP, OPND_TOP, OPND_MAX);
    send(OPND_W'({(OPND_W/2){2'b01}}), OPND_W'({(OPND_W/2){2'b10}}),
         OPND_MAX - OPND_W'(24));
    send(OPND_MAX, '0, OPND_W'(5));
    send(OPND_W'(5), OPND_W'(7), OPND_W'(3));
    send(OPND_MAX, OPND_MAX, OPND_W'(2));
    send(OPND_TOP - 1'b1, OPND_MAX, OPND_TOP - 1'b1);

    // Random operand triples
    repeat (RAND_ITEMS) begin
      m = rand_modulus();
      send(rand_factor(m), rand_factor(m), m);
    end

    // Drain and let the engine settle
    @(negedge clk);
    in_valid = 1'b0;
    @(posedge clk);
    while (products_due != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0 && products_due == 0) begin
      $display("modular_multiplier_63bit_test: done, clean");
    end else begin
      $display("modular_multiplier_63bit_test: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #30_000_000;
    $display("modular_multiplier_63bit_test: done, errors");
    $finish;
  end

endmodule
